// File: rtl/core/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and constants for the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_SERVED  = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic CFG_QUEUE_LIMIT = 1'b0;
  localparam logic CFG_REQ_TOTAL   = 1'b1;

  // Fixed field widths
  localparam int REQ_W   = 4;
  localparam int TRACK_W = 16;
  localparam int CFG_W   = 5;

  // Services allowed per accepted item
  localparam logic [3:0] SERVICE_LIMIT = 4'd15;

  // Reset value of the requester total register
  localparam int REQ_TOTAL_RESET = 16;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic evaluate;
    logic emit;
    logic scan_start;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic more;
    logic scan_done;
  } dp_stat_t;

endpackage

// File: rtl/core/sstf_ctrl.sv
// ----------------------------------------------------------------------------
// sstf_ctrl
// Controller: sequences accept, check, result emission and the seek scans.
// ----------------------------------------------------------------------------
module sstf_ctrl import sstf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.evaluate = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.more) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/sstf_dp.sv
// ----------------------------------------------------------------------------
// sstf_dp
// Datapath: slot store, counters, head position, seek scan and output register.
// ----------------------------------------------------------------------------
module sstf_dp import sstf_pkg::*; #(
  parameter int MAX_REQUESTERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [REQ_W-1:0]   in_requester,
  input  logic [TRACK_W-1:0] in_track,
  input  logic               in_final_request,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [REQ_W-1:0]   out_served_requester,
  output logic [TRACK_W-1:0] out_served_track,
  output logic               out_last,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat
);

  localparam int IW = $clog2(MAX_REQUESTERS);
  localparam int CW = $clog2(MAX_REQUESTERS + 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_REQUESTERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_REQUESTERS - 1);
  localparam logic [CW-1:0] TOTAL_RST =
    CW'((MAX_REQUESTERS < REQ_TOTAL_RESET) ? MAX_REQUESTERS : REQ_TOTAL_RESET);

  // Latched input item
  logic [REQ_W-1:0]   req_r;
  logic [TRACK_W-1:0] trk_r;
  logic               fin_r;

  // Configuration and scheduler state
  logic [CFG_W-1:0]          qlim_r;
  logic [CW-1:0]             active_r;
  logic [CW-1:0]             pending_r;
  logic [TRACK_W-1:0]        head_r;
  logic [MAX_REQUESTERS-1:0] slot_valid_r;
  logic [TRACK_W-1:0]        slot_track_mem [MAX_REQUESTERS];
  logic [3:0]                guard_r;
  logic                      refused_r;

  // Result waiting for the output register
  status_t            held_status_r;
  logic [REQ_W-1:0]   held_who_r;
  logic [TRACK_W-1:0] held_trk_r;

  // Seek scan
  logic               issuing_r;
  logic [IW-1:0]      scan_idx_r;
  logic               rd_vld_r;
  logic [IW-1:0]      rd_idx_r;
  logic [TRACK_W-1:0] rd_data_r;
  logic               found_r;
  logic [IW-1:0]      best_idx_r;
  logic [TRACK_W-1:0] best_trk_r;
  logic [TRACK_W-1:0] best_d_r;

  // Output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [REQ_W-1:0]   out_who_r;
  logic [TRACK_W-1:0] out_trk_r;
  logic               out_last_r;

  logic [CW-1:0]      lim_c;
  logic [CW-1:0]      eff_c;
  logic [CW-1:0]      total_c;
  logic [IW-1:0]      who_idx;
  logic               who_oob;
  logic               refuse_c;
  logic               more_c;
  logic [TRACK_W-1:0] dist_c;
  logic               better_c;
  logic               out_free;

  // Clamp queue limit and form the effective queue size
  always_comb begin
    if (qlim_r == '0) begin
      lim_c = CW'(1);
    end else if (32'(qlim_r) > 32'(MAX_REQUESTERS)) begin
      lim_c = MAX_CNT;
    end else begin
      lim_c = CW'(qlim_r);
    end
    eff_c = (lim_c < active_r) ? lim_c : active_r;
  end

  // Clamp a written requester total
  assign total_c = (32'(cfg_wdata) > 32'(MAX_REQUESTERS)) ? MAX_CNT : CW'(cfg_wdata);

  // Accept decision for the latched item
  assign who_idx  = IW'(req_r);
  assign who_oob  = 32'(req_r) >= 32'(MAX_REQUESTERS);
  assign refuse_c = who_oob || slot_valid_r[who_idx] || (pending_r >= eff_c);

  // For a queued item, services go on while pending >= size, to the service limit
  assign more_c = !refused_r && (pending_r != '0) && (pending_r >= eff_c) &&
                  (guard_r != SERVICE_LIMIT);

  // Seek distance of the entry coming out of the store
  assign dist_c   = (rd_data_r >= head_r) ? (rd_data_r - head_r) : (head_r - rd_data_r);
  assign better_c = rd_vld_r && slot_valid_r[rd_idx_r] && (!found_r || dist_c < best_d_r);

  assign out_free = !out_valid_r || !out_stall;

  assign stat.out_free  = out_free;
  assign stat.more      = more_c;
  assign stat.scan_done = !issuing_r && !rd_vld_r;

  // Track store: write on accept, registered read during the scan
  always_ff @(posedge clk) begin
    if (cmd.evaluate && !refuse_c) begin
      slot_track_mem[who_idx] <= trk_r;
    end
    rd_data_r <= slot_track_mem[scan_idx_r];
    rd_idx_r  <= scan_idx_r;
  end

  // Input latch, held result and best candidate payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_requester;
      trk_r <= in_track;
      fin_r <= in_final_request;
    end
    if (cmd.evaluate) begin
      held_status_r <= refuse_c ? ST_REFUSED : ST_QUEUED;
      held_who_r    <= '0;
      held_trk_r    <= '0;
    end else if (cmd.commit) begin
      held_status_r <= ST_SERVED;
      held_who_r    <= REQ_W'(best_idx_r);
      held_trk_r    <= best_trk_r;
    end
    if (better_c) begin
      best_idx_r <= rd_idx_r;
      best_trk_r <= rd_data_r;
      best_d_r   <= dist_c;
    end
    if (cmd.emit) begin
      out_status_r <= held_status_r;
      out_who_r    <= held_who_r;
      out_trk_r    <= held_trk_r;
      out_last_r   <= !more_c;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlim_r       <= CFG_W'(4);
      active_r     <= TOTAL_RST;
      pending_r    <= '0;
      head_r       <= '0;
      slot_valid_r <= '0;
      guard_r      <= '0;
      refused_r    <= 1'b0;
      issuing_r    <= 1'b0;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        if (cfg_index == CFG_QUEUE_LIMIT) begin
          qlim_r <= cfg_wdata;
        end else if (cfg_index == CFG_REQ_TOTAL) begin
          active_r <= total_c;
        end
      end

      // Queue the item or refuse it
      if (cmd.evaluate) begin
        refused_r <= refuse_c;
        guard_r   <= '0;
        if (!refuse_c) begin
          slot_valid_r[who_idx] <= 1'b1;
          pending_r             <= pending_r + CW'(1);
          if (fin_r && active_r != '0) begin
            active_r <= active_r - CW'(1);
          end
        end
      end

      // Service the nearest entry and move the head
      if (cmd.commit) begin
        head_r                   <= best_trk_r;
        slot_valid_r[best_idx_r] <= 1'b0;
        pending_r                <= pending_r - CW'(1);
        guard_r                  <= guard_r + 4'd1;
      end

      // Walk the slots, one read per cycle
      if (cmd.scan_start) begin
        issuing_r  <= 1'b1;
        scan_idx_r <= '0;
        rd_vld_r   <= 1'b0;
        found_r    <= 1'b0;
      end else begin
        rd_vld_r <= issuing_r;
        if (issuing_r) begin
          if (scan_idx_r == LAST_IDX) begin
            issuing_r <= 1'b0;
          end else begin
            scan_idx_r <= scan_idx_r + IW'(1);
          end
        end
        if (better_c) begin
          found_r <= 1'b1;
        end
      end

      // Output handshake
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_served_requester = out_who_r;
  assign out_served_track     = out_trk_r;
  assign out_last             = out_last_r;

endmodule

// File: rtl/core/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler
// Shortest-seek-time-first scheduler holding one pending track per requester.
// ----------------------------------------------------------------------------
// One item is taken at a time. A refused item has its result loaded in the
// output register in the emit state after the check state, and the next item
// can then be taken in idle; a queued item gets one more result for each
// service it triggers, since every service scans all slots through the track
// store, one read per cycle, before the head moves. A stalled result holds
// the next one back until the output register frees. The block takes a new
// item while the previous final result still waits in the output register.
// Configuration writes must only occur while idle.
module sstf_disk_request_scheduler import sstf_pkg::*; #(
  parameter int MAX_REQUESTERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   in_requester,
  input  logic [TRACK_W-1:0] in_track,
  input  logic               in_final_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [REQ_W-1:0]   out_served_requester,
  output logic [TRACK_W-1:0] out_served_track,
  output logic               out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, counters and scan
  sstf_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_requester         (in_requester),
    .in_track             (in_track),
    .in_final_request     (in_final_request),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_served_requester (out_served_requester),
    .out_served_track     (out_served_track),
    .out_last             (out_last),
    .cmd                  (cmd),
    .stat                 (stat)
  );

endmodule
